[hw/rtl/u8u16_pkg.sv]
// Shared types, constants and the byte classifier for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic plan_has;
    logic plan_last;
    logic out_free;
  } dp_status_t;

  localparam logic [2:0] CLS_CONT  = 3'd0;
  localparam logic [2:0] CLS_ASCII = 3'd1;
  localparam logic [2:0] CLS_LEAD2 = 3'd2;
  localparam logic [2:0] CLS_LEAD3 = 3'd3;
  localparam logic [2:0] CLS_LEAD4 = 3'd4;
  localparam logic [2:0] CLS_BAD   = 3'd5;

  localparam logic [15:0] REPL_CHAR    = 16'h003F;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [5:0]  SURR_LO_TOP  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  function automatic logic [2:0] byte_class(input logic [7:0] b);
    logic [2:0] cls;
    unique case (b[7:3]) inside
      [5'd0:5'd15]:  cls = CLS_ASCII;
      [5'd16:5'd23]: cls = CLS_CONT;
      [5'd24:5'd27]: cls = CLS_LEAD2;
      [5'd28:5'd29]: cls = CLS_LEAD3;
      5'd30:         cls = CLS_LEAD4;
      default:       cls = CLS_BAD;
    endcase
    return cls;
  endfunction

endpackage

[hw/rtl/u8u16_ctrl.sv]
// Controller state machine that sequences byte transfers and result emission.
module u8u16_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u8u16_pkg::dp_status_t status,
  output u8u16_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.pop    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status.plan_has) begin
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          cmd.pop = 1'b1;
          if (status.plan_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/u8u16_dp.sv]
// Datapath with the pending byte buffer, result plan and output register.
module u8u16_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u8u16_pkg::in_t        in_data,
  input  u8u16_pkg::ctrl_cmd_t  cmd,
  output u8u16_pkg::dp_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u8u16_pkg::out_t       out_data
);

  logic [7:0]       pend_r [3];
  logic [7:0]       pend_nxt [3];
  logic [1:0]       pcount_r, pcount_nxt;
  logic [2:0]       seqlen_r, seqlen_nxt;
  logic [2:0]       rep_left_r, rep_left_nxt;
  logic [1:0]       tail_cnt_r, tail_cnt_nxt;
  logic [15:0]      unit0_r, unit0_nxt;
  logic [15:0]      unit1_r, unit1_nxt;
  logic             out_valid_r;
  u8u16_pkg::out_t  out_data_r, out_data_nxt;

  logic [2:0]  cls;
  logic [5:0]  cbits;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [3:0]  plan_total;
  logic [2:0]  rep_new;
  logic [1:0]  tail_new;
  logic [15:0] u0_new, u1_new;
  logic        as_lead;

  assign cls    = u8u16_pkg::byte_class(in_data.in_byte);
  assign cbits  = in_data.in_byte[5:0];
  assign cp_off = cp - u8u16_pkg::SUPP_BASE;

  always_comb begin
    unique case (seqlen_r)
      u8u16_pkg::CLS_LEAD2: cp = {10'd0, pend_r[0][4:0], cbits};
      u8u16_pkg::CLS_LEAD3: cp = {5'd0, pend_r[0][3:0], pend_r[1][5:0], cbits};
      default: cp = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], cbits};
    endcase
  end

  always_comb begin
    pend_nxt   = pend_r;
    pcount_nxt = pcount_r;
    seqlen_nxt = seqlen_r;
    rep_new    = 3'd0;
    tail_new   = 2'd0;
    u0_new     = unit0_r;
    u1_new     = unit1_r;
    as_lead    = 1'b1;
    if (pcount_r != 2'd0) begin
      if (cls == u8u16_pkg::CLS_CONT) begin
        as_lead = 1'b0;
        if (({1'b0, pcount_r} + 3'd1) == seqlen_r) begin
          if (cp < u8u16_pkg::SUPP_BASE) begin
            tail_new = 2'd1;
            u0_new   = cp[15:0];
          end else begin
            tail_new = 2'd2;
            u0_new   = u8u16_pkg::SURR_HI_BASE + {5'd0, cp_off[20:10]};
            u1_new   = {u8u16_pkg::SURR_LO_TOP, cp_off[9:0]};
          end
          pcount_nxt = 2'd0;
          seqlen_nxt = 3'd0;
        end else if (in_data.end_of_string) begin
          rep_new    = {1'b0, pcount_r} + 3'd1;
          pcount_nxt = 2'd0;
          seqlen_nxt = 3'd0;
        end else begin
          if (pcount_r == 2'd1) begin
            pend_nxt[1] = in_data.in_byte;
          end else begin
            pend_nxt[2] = in_data.in_byte;
          end
          pcount_nxt = pcount_r + 2'd1;
        end
      end else begin
        rep_new    = {1'b0, pcount_r};
        pcount_nxt = 2'd0;
        seqlen_nxt = 3'd0;
      end
    end else begin
      pcount_nxt = 2'd0;
      seqlen_nxt = 3'd0;
    end
    if (as_lead) begin
      if (cls == u8u16_pkg::CLS_ASCII) begin
        tail_new = 2'd1;
        u0_new   = {8'd0, in_data.in_byte};
      end else if (cls == u8u16_pkg::CLS_CONT || cls == u8u16_pkg::CLS_BAD ||
                   in_data.end_of_string) begin
        rep_new = rep_new + 3'd1;
      end else begin
        pend_nxt[0] = in_data.in_byte;
        pcount_nxt  = 2'd1;
        seqlen_nxt  = cls;
      end
    end
  end

  assign plan_total       = {1'b0, rep_left_r} + {2'd0, tail_cnt_r};
  assign status.plan_has  = (plan_total != 4'd0);
  assign status.plan_last = (plan_total == 4'd1);
  assign status.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    rep_left_nxt = rep_left_r;
    tail_cnt_nxt = tail_cnt_r;
    unit0_nxt    = unit0_r;
    unit1_nxt    = unit1_r;
    out_data_nxt = out_data_r;
    if (cmd.accept) begin
      rep_left_nxt = rep_new;
      tail_cnt_nxt = tail_new;
      unit0_nxt    = u0_new;
      unit1_nxt    = u1_new;
    end else if (cmd.pop) begin
      out_data_nxt.run_last = status.plan_last;
      if (rep_left_r != 3'd0) begin
        out_data_nxt.code_unit = u8u16_pkg::REPL_CHAR;
        out_data_nxt.replaced  = 1'b1;
        rep_left_nxt           = rep_left_r - 3'd1;
      end else begin
        out_data_nxt.code_unit = unit0_r;
        out_data_nxt.replaced  = 1'b0;
        tail_cnt_nxt           = tail_cnt_r - 2'd1;
        unit0_nxt              = unit1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r    <= 2'd0;
      seqlen_r    <= 3'd0;
      rep_left_r  <= 3'd0;
      tail_cnt_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pcount_r <= pcount_nxt;
        seqlen_r <= seqlen_nxt;
      end
      rep_left_r <= rep_left_nxt;
      tail_cnt_r <= tail_cnt_nxt;
      if (cmd.pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_r <= pend_nxt;
    end
    unit0_r    <= unit0_nxt;
    unit1_r    <= unit1_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/utf8_to_utf16_transcoder_top.sv]
// Top level of the UTF-8 to UTF-16 transcoder.
// The input channel takes one UTF-8 byte per transfer with an end-of-string
// flag. The output channel gives UTF-16 code units, each flagged when it is a
// replacement '?' and marked run_last on the final unit caused by its byte.
// A byte may cause no unit (it is buffered), one unit, a surrogate pair, or up
// to four replacement units when a sequence breaks.
// A byte transfer loads the planned results at once, and the units then leave
// one per cycle, while the receiver does not stall, through the single output
// register. The next byte is taken in the cycle after the last unit is loaded;
// a buffered byte with no units frees the input once the emit state finds no plan.
// The first unit goes from the plan registers into the output register.
// The next byte is taken while the last unit of the previous one still waits.
// Reset clears the pending sequence and any planned units; the block then
// takes a byte at once. When the receiver stalls, the output register holds
// its unit and emission pauses until the transfer completes.
module utf8_to_utf16_transcoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  u8u16_pkg::in_t     in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output u8u16_pkg::out_t    out_data
);

  u8u16_pkg::ctrl_cmd_t  cmd;
  u8u16_pkg::dp_status_t status;

  u8u16_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  u8u16_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
